/* src/irpd_pkg.sv */
`default_nettype none

package irpd_pkg;

    // Frame geometry
    localparam int DATA_BITS         = 11;
    localparam int INTERVAL_CAPACITY = 50;
    localparam int IDX_W             = $clog2(INTERVAL_CAPACITY + 1);
    localparam int BITS_W            = $clog2(DATA_BITS + 1);
    localparam int IV_W              = 16;

    // Fixed timing and acceptance limits
    localparam logic [IV_W-1:0]   MARK_MIN  = 16'd400;
    localparam logic [IV_W-1:0]   MARK_MAX  = 16'd12500;
    localparam logic [IDX_W-1:0]  COUNT_MIN = IDX_W'(23);
    localparam logic [IDX_W-1:0]  COUNT_MAX = IDX_W'(25);
    localparam logic [BITS_W-1:0] MIN_BITS  = BITS_W'(8);

    // Operation codes
    localparam logic OP_INTERVAL = 1'b0;
    localparam logic OP_END      = 1'b1;

    // Configuration register indexes
    localparam int CFG_NUM = 8;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE_MIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE_MAX  = 3'd7;

    // Window set handed from the register file to the decoder
    typedef struct packed {
        logic [IV_W-1:0] lead_mark_min;
        logic [IV_W-1:0] lead_mark_max;
        logic [IV_W-1:0] lead_space_min;
        logic [IV_W-1:0] lead_space_max;
        logic [IV_W-1:0] zero_space_min;
        logic [IV_W-1:0] zero_space_max;
        logic [IV_W-1:0] one_space_min;
        logic [IV_W-1:0] one_space_max;
    } t_cfg;

    // Frame verdict from the decoder
    typedef struct packed {
        logic                 frame_ok;
        logic [DATA_BITS-1:0] frame_code;
        logic [3:0]           dev_addr;
        logic [6:0]           command;
        logic [3:0]           bit_total;
    } t_result;

    function automatic logic in_window(input logic [IV_W-1:0] v,
                                       input logic [IV_W-1:0] lo,
                                       input logic [IV_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

`default_nettype wire

/* src/irpd_cfg_regs.sv */
`default_nettype none

module irpd_cfg_regs
    import irpd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [IV_W-1:0]      i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Window registers, written one at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_mark_min  <= 16'd10000;
            r_cfg.lead_mark_max  <= 16'd11100;
            r_cfg.lead_space_min <= 16'd1600;
            r_cfg.lead_space_max <= 16'd1800;
            r_cfg.zero_space_min <= 16'd450;
            r_cfg.zero_space_max <= 16'd650;
            r_cfg.one_space_min  <= 16'd1600;
            r_cfg.one_space_max  <= 16'd1750;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LEAD_MARK_MIN:  r_cfg.lead_mark_min  <= i_cfg_data;
                CFG_LEAD_MARK_MAX:  r_cfg.lead_mark_max  <= i_cfg_data;
                CFG_LEAD_SPACE_MIN: r_cfg.lead_space_min <= i_cfg_data;
                CFG_LEAD_SPACE_MAX: r_cfg.lead_space_max <= i_cfg_data;
                CFG_ZERO_SPACE_MIN: r_cfg.zero_space_min <= i_cfg_data;
                CFG_ZERO_SPACE_MAX: r_cfg.zero_space_max <= i_cfg_data;
                CFG_ONE_SPACE_MIN:  r_cfg.one_space_min  <= i_cfg_data;
                CFG_ONE_SPACE_MAX:  r_cfg.one_space_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/irpd_frame_core.sv */
`default_nettype none

module irpd_frame_core
    import irpd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic            i_op,
    input  wire logic [IV_W-1:0] i_interval_us,
    input  t_cfg                 i_cfg,
    output t_result              o_result
);

    logic [IDX_W-1:0]     r_idx,       n_idx;
    logic                 r_lead_ok,   n_lead_ok;
    logic [IV_W-1:0]      r_held_mark, n_held_mark;
    logic [DATA_BITS-1:0] r_shift,     n_shift;
    logic [BITS_W-1:0]    r_bits,      n_bits;

    logic w_full;
    logic w_pair_ok;
    logic w_is_zero;
    logic w_is_one;
    logic w_ok;

    assign w_full    = (r_idx >= IDX_W'(INTERVAL_CAPACITY));
    assign w_pair_ok = (r_bits < BITS_W'(DATA_BITS)) &&
                       in_window(r_held_mark, MARK_MIN, MARK_MAX);
    assign w_is_zero = in_window(i_interval_us, i_cfg.zero_space_min, i_cfg.zero_space_max);
    assign w_is_one  = in_window(i_interval_us, i_cfg.one_space_min, i_cfg.one_space_max);

    // Next state for one interval beat or a frame end
    always_comb begin
        n_idx       = r_idx;
        n_lead_ok   = r_lead_ok;
        n_held_mark = r_held_mark;
        n_shift     = r_shift;
        n_bits      = r_bits;
        if (i_op == OP_END) begin
            n_idx       = '0;
            n_lead_ok   = 1'b1;
            n_held_mark = '0;
            n_shift     = '0;
            n_bits      = '0;
        end else if (!w_full) begin
            if (r_idx == IDX_W'(0)) begin
                if (!in_window(i_interval_us, i_cfg.lead_mark_min, i_cfg.lead_mark_max))
                    n_lead_ok = 1'b0;
            end else if (r_idx == IDX_W'(1)) begin
                if (!in_window(i_interval_us, i_cfg.lead_space_min, i_cfg.lead_space_max))
                    n_lead_ok = 1'b0;
            end else if (!r_idx[0]) begin
                // even index: mark, hold it for its space
                n_held_mark = i_interval_us;
            end else if (w_pair_ok) begin
                // odd index: space decides the bit
                if (w_is_zero) begin
                    n_shift = {r_shift[DATA_BITS-2:0], 1'b0};
                    n_bits  = r_bits + BITS_W'(1);
                end else if (w_is_one) begin
                    n_shift = {r_shift[DATA_BITS-2:0], 1'b1};
                    n_bits  = r_bits + BITS_W'(1);
                end
            end
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_lead_ok   <= 1'b1;
            r_held_mark <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
        end else if (i_fire) begin
            r_idx       <= n_idx;
            r_lead_ok   <= n_lead_ok;
            r_held_mark <= n_held_mark;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
        end
    end

    // Frame verdict from the current state
    assign w_ok = (r_idx >= COUNT_MIN) && (r_idx <= COUNT_MAX) &&
                  r_lead_ok && (r_bits >= MIN_BITS);

    always_comb begin
        o_result = '0;
        if (w_ok) begin
            o_result.frame_ok   = 1'b1;
            o_result.frame_code = r_shift;
            o_result.dev_addr   = r_shift[DATA_BITS-1 -: 4];
            o_result.command    = r_shift[6:0];
            o_result.bit_total  = 4'(r_bits);
        end
    end

    // Checks
    a_bits_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BITS_W'(DATA_BITS))
        else $error("bit count beyond capacity");

    a_idx_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(INTERVAL_CAPACITY))
        else $error("interval index beyond capacity");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_END) |=> (r_idx == '0 && r_bits == '0 && r_lead_ok))
        else $error("state not cleared after frame end");

    a_ok_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.frame_ok |-> (r_bits >= MIN_BITS && r_idx >= COUNT_MIN))
        else $error("frame accepted without enough bits or intervals");

endmodule

`default_nettype wire

/* src/ir_pulse_distance_frame_decoder.sv */
`default_nettype none

// IR pulse-distance frame decoder. Each input beat carries one measured
// edge-to-edge interval in microseconds (operation 0) or a frame-end marker
// (operation 1); only a frame-end beat produces a result beat, carrying the
// verdict, the decoded code, its device and command fields and the bit count.
// One beat is taken every clock cycle while input is not held back: a beat
// is registered at the input, then decoded by window compares and a shift
// and, for a frame end, passes on from there into the output register.
// Input is held back only while a frame-end beat waits for a full output
// register. The user writes timing windows through the configuration port
// only while no frame is in flight; the block does not enforce this.
module ir_pulse_distance_frame_decoder
    import irpd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [IV_W-1:0]      i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_operation,
    input  wire logic [IV_W-1:0]      i_interval_us,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_frame_ok,
    output logic [DATA_BITS-1:0]      o_frame_code,
    output logic [3:0]                o_dev_addr,
    output logic [6:0]                o_command,
    output logic [3:0]                o_bit_total
);

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_out;

    logic            r_in_valid;
    logic            r_in_op;
    logic [IV_W-1:0] r_in_iv;
    logic            r_out_valid;
    logic            w_adv;

    irpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    irpd_frame_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_adv),
        .i_op          (r_in_op),
        .i_interval_us (r_in_iv),
        .i_cfg         (w_cfg),
        .o_result      (w_result)
    );

    // Intervals always advance; a frame end needs room at the output
    assign w_adv      = r_in_valid && (r_in_op == OP_INTERVAL || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op <= i_operation;
            r_in_iv <= i_interval_us;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_op == OP_END) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_op == OP_END) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_ok   = r_out.frame_ok;
    assign o_frame_code = r_out.frame_code;
    assign o_dev_addr   = r_out.dev_addr;
    assign o_command    = r_out.command;
    assign o_bit_total  = r_out.bit_total;

    // Checks
    a_stall_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |-> (r_in_op == OP_END && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked frame end");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_op == OP_END) |=> r_out_valid)
        else $error("frame end beat did not reach the output");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_ok) |-> (r_out.frame_code == '0 && r_out.bit_total == '0))
        else $error("failed frame carries nonzero fields");

endmodule

`default_nettype wire
